/* sv/sample_time_correction_macros.svh */
// Assertion macros for the sample time correction block.
// Depends on nothing; included by the top level.
`ifndef SAMPLE_TIME_CORRECTION_MACROS_SVH
`define SAMPLE_TIME_CORRECTION_MACROS_SVH
// Implication check, clocked on clk, muted during reset.
`define STC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stc check failed");
// Next-cycle implication check.
`define STC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stc check failed");
`endif

/* sv/stc_pkg.sv */
// Package for the sample time correction block: constants and state type.
// Depends on nothing.
package stc_pkg;
	localparam int unsigned ASIC_COUNT_D = 8;
	localparam int unsigned RING_SAMPLES_D = 256;
	localparam int unsigned WINDOW_SAMPLES_D = 64;
	localparam int unsigned FRAC_BITS = 12;
	localparam int unsigned OUT_W = 27;
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_HIT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK1,
		ST_LOOK2,
		ST_MUL,
		ST_OUT
	} stc_state_t;
endpackage

/* sv/sample_time_correction.sv */
// Sample time correction: per-ASIC width tables with prefix sums, hit calibration.
// Depends on stc_pkg and sample_time_correction_macros.svh.
// Load beat: busy after the accept edge while the prefix table of that ASIC is rebuilt bin
// by bin, and no new beat is taken until the rebuild is done. Hit beat: busy is high through
// the states LOOK1, LOOK2, MUL and OUT, and low during the strobe, registered from ST_OUT.
// Reset clears the loaded flags and the controller; the table memories keep their contents.
module sample_time_correction #(
	parameter int unsigned WINDOW_SAMPLES = stc_pkg::WINDOW_SAMPLES_D
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         func,
	input  logic [2:0]                   asic,
	input  logic [7:0]                   bin_index,
	input  logic [13:0]                  width_value,
	input  logic [8:0]                   window,
	input  logic [23:0]                  start_bin,
	input  logic [23:0]                  hit_width,
	output logic                         strobe,
	output logic                         status,
	output logic [stc_pkg::OUT_W-1:0]    corrected_start,
	output logic signed [stc_pkg::OUT_W-1:0] corrected_width,
	output logic signed [stc_pkg::OUT_W-1:0] delta
);
	import stc_pkg::*;
	`include "sample_time_correction_macros.svh"

	localparam int unsigned ASIC_COUNT = ASIC_COUNT_D;
	localparam int unsigned RING_SAMPLES = RING_SAMPLES_D;
	localparam int unsigned BINS = RING_SAMPLES - 1;
	localparam int unsigned RB = $clog2(RING_SAMPLES);
	localparam int unsigned AB = (ASIC_COUNT > 1) ? $clog2(ASIC_COUNT) : 1;
	localparam int unsigned DEPTH = ASIC_COUNT * RING_SAMPLES;
	localparam int unsigned MB = AB + RB;
	localparam int unsigned PB = RB + 15; // prefix sum width
	localparam int unsigned POSB = RB + FRAC_BITS;
	localparam int unsigned SB = 27;      // s1, s2 width
	localparam logic [SB-1:0] WIN_Q = SB'(WINDOW_SAMPLES) << FRAC_BITS;
	localparam logic signed [PB+1:0] RING_Q = (PB+2)'(RING_SAMPLES) << FRAC_BITS;

	// Width memory and prefix memory: prefix[a][b] holds sum of widths below bin b.
	logic [13:0]   wmem [DEPTH];
	logic [PB-1:0] pmem [DEPTH];
	logic [ASIC_COUNT-1:0] present_q;

	stc_state_t state_q, state_d;
	logic [AB-1:0] asic_q;
	logic [SB-1:0] s1_q, s2_q;
	logic miss_q;
	logic [13:0]   wrd_q;
	logic [PB-1:0] prd_q;
	logic [13:0]   w1_q;
	logic [PB-1:0] p1_q;
	logic [FRAC_BITS-1:0] f1_q;
	logic last1_q;
	logic signed [48:0] t1_q, t2_q;
	logic signed [48:0] m1_q, m2_q;

	// Prefix maintenance sweep after a load: rebuild prefix of one ASIC bin by bin.
	logic          sweep_q;
	logic [AB-1:0] sw_asic_q;
	logic [RB-1:0] sw_bin_q;
	logic [PB-1:0] sw_acc_q;
	logic [13:0]   sw_w;
	logic [PB-1:0] sw_sum;

	logic acc;
	logic asic_ok;
	assign acc = start && !busy;
	assign asic_ok = 32'(asic) < ASIC_COUNT;

	// Address mux for reads.
	logic [MB-1:0] raddr;
	logic [SB-1:0] rpos;
	always_comb begin
		rpos = (state_q == ST_LOOK1) ? s1_q : s2_q;
		raddr = {asic_q, rpos[FRAC_BITS +: RB]};
		if (sweep_q) raddr = {sw_asic_q, sw_bin_q};
	end

	// Sum below the swept bin: the width read lags one bin behind the write.
	assign sw_sum = (sw_bin_q == '0) ? '0 : sw_acc_q + PB'(sw_w);

	// Memory write and registered read.
	always_ff @(posedge clk) begin
		if (acc && func == FUNC_LOAD && asic_ok && 32'(bin_index) < BINS)
			wmem[{asic[AB-1:0], bin_index[RB-1:0]}] <= width_value;
		if (sweep_q)
			pmem[{sw_asic_q, sw_bin_q}] <= sw_sum;
		wrd_q <= wmem[raddr];
		prd_q <= pmem[raddr];
	end
	assign sw_w = wrd_q;

	// Controller.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			present_q <= '0;
			sweep_q <= 1'b0;
			sw_bin_q <= '0;
			sw_asic_q <= '0;
			sw_acc_q <= '0;
		end else begin
			state_q <= state_d;
			if (acc && func == FUNC_LOAD && asic_ok && 32'(bin_index) < BINS) begin
				present_q[asic[AB-1:0]] <= 1'b1;
				sweep_q <= 1'b1;
				sw_asic_q <= asic[AB-1:0];
				sw_bin_q <= '0;
				sw_acc_q <= '0;
			end else if (sweep_q) begin
				// advance one bin and hold the running sum
				sw_bin_q <= sw_bin_q + 1'b1;
				sw_acc_q <= sw_sum;
				if (sw_bin_q == RB'(RING_SAMPLES - 1)) sweep_q <= 1'b0;
			end
		end
	end

	// The sweep reads width k-1 while writing prefix k; prefix k = prefix k-1 + width k-1.

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (acc && func == FUNC_HIT) state_d = ST_LOOK1;
			ST_LOOK1: state_d = ST_LOOK2;
			ST_LOOK2: state_d = ST_MUL;
			ST_MUL:   state_d = ST_OUT;
			ST_OUT:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end
	assign busy = (state_q != ST_IDLE) || sweep_q;

	// Capture hit, compute ring positions.
	logic [SB-1:0] s1_c;
	assign s1_c = SB'(start_bin) + SB'(window[1:0]) * WIN_Q;
	logic signed [48:0] ring1, ring2;
	always_ff @(posedge clk) begin
		if (acc) begin
			asic_q <= asic[AB-1:0];
			miss_q <= !asic_ok || !present_q[asic[AB-1:0]];
			s1_q <= s1_c;
			s2_q <= s1_c + SB'(hit_width);
		end
		if (state_q == ST_LOOK2) begin
			w1_q <= wrd_q;
			p1_q <= prd_q;
			f1_q <= s1_q[FRAC_BITS-1:0];
			last1_q <= s1_q[FRAC_BITS +: RB] == RB'(RING_SAMPLES - 1);
		end
		if (state_q == ST_MUL) begin
			m1_q <= 49'(signed'({1'b0, f1_q})) * (last1_q ?
				(RING_Q - (PB+2)'(signed'({2'b0, p1_q}))) : (PB+2)'(signed'({2'b0, PB'(w1_q)})));
			m2_q <= 49'(signed'({1'b0, s2_q[FRAC_BITS-1:0]}))
				* ((s2_q[FRAC_BITS +: RB] == RB'(RING_SAMPLES - 1)) ?
				(RING_Q - (PB+2)'(signed'({2'b0, prd_q}))) : (PB+2)'(signed'({2'b0, PB'(wrd_q)})));
			t1_q <= 49'(signed'({2'b0, p1_q})) + ring1;
			t2_q <= 49'(signed'({2'b0, prd_q})) + ring2;
		end
	end
	// Whole rings: clear the position within the ring.
	assign ring1 = 49'(signed'({1'b0, (s1_q >> POSB) << POSB}));
	assign ring2 = 49'(signed'({1'b0, (s2_q >> POSB) << POSB}));

	// Round half up: floor((p+2048)/4096) via arithmetic shift.
	logic signed [48:0] r1, r2, tt1, tt2, cw, dl;
	always_comb begin
		r1 = (m1_q + 49'sd2048) >>> FRAC_BITS;
		r2 = (m2_q + 49'sd2048) >>> FRAC_BITS;
		tt1 = t1_q + r1;
		tt2 = t2_q + r2;
		cw = tt2 - tt1;
		dl = 49'(signed'({1'b0, s1_q})) - tt1;
	end

	// Saturate and drive result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) strobe <= 1'b0;
		else strobe <= (state_q == ST_OUT);
	end
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT) begin
			status <= miss_q;
			if (miss_q) begin
				corrected_start <= '0;
				corrected_width <= '0;
				delta <= '0;
			end else begin
				corrected_start <= tt1 < 0 ? '0 : (tt1 > 49'sd134217727 ? '1 : OUT_W'(tt1));
				corrected_width <= cw < -49'sd67108864 ? {1'b1, {(OUT_W-1){1'b0}}} :
					(cw > 49'sd67108863 ? {1'b0, {(OUT_W-1){1'b1}}} : OUT_W'(cw));
				delta <= dl < -49'sd67108864 ? {1'b1, {(OUT_W-1){1'b0}}} :
					(dl > 49'sd67108863 ? {1'b0, {(OUT_W-1){1'b1}}} : OUT_W'(dl));
			end
		end
	end

	`STC_ASSERT_NXT(a_hit_busy, acc && func == FUNC_HIT, busy)
	`STC_ASSERT_IMP(a_strobe_state, strobe, $past(state_q) == ST_OUT)
	`STC_ASSERT_IMP(a_no_accept_sweep, sweep_q, busy)
endmodule

/* tb/sample_time_correction_tb.sv */
// Testbench for sample_time_correction: table loads and hit calibration against a predictor.
// Depends on stc_pkg and the sample_time_correction RTL.
module sample_time_correction_tb;
	import stc_pkg::*;

	localparam int unsigned BINS = RING_SAMPLES_D - 1;
	localparam longint RING_Q = longint'(RING_SAMPLES_D) << FRAC_BITS;
	localparam int unsigned CYCLE_LIMIT = 2000000;

	typedef struct {
		bit        status;
		bit [26:0] cstart;
		bit [26:0] cwidth;
		bit [26:0] dlt;
	} hit_result_t;

	// Calibration predictor and store of pending hit results
	class hit_scoreboard;
		bit [13:0]   widths [ASIC_COUNT_D][BINS];
		bit          loaded [ASIC_COUNT_D];
		hit_result_t pending[$];
		int          errors;

		function void clear();
			foreach (loaded[i]) loaded[i] = 0;
			pending.delete();
			errors = 0;
		endfunction

		// Round to nearest, halves toward plus infinity
		function longint round_half_up(longint p);
			longint q;
			q = p + 2048;
			if (q >= 0) return q >>> FRAC_BITS;
			return -((-q + 4095) >>> FRAC_BITS);
		endfunction

		function longint ring_time(int a, longint s);
			longint ring, pos, bin, frac, t;
			ring = s / RING_Q;
			pos = s % RING_Q;
			bin = pos >>> FRAC_BITS;
			frac = pos & 4095;
			t = 0;
			for (int k = 0; k < bin && k < BINS; k++) t += widths[a][k];
			if (bin < BINS) t += round_half_up(frac * widths[a][bin]);
			else t += round_half_up(frac * (RING_Q - t));
			return t + ring * RING_Q;
		endfunction

		function longint clip(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		// Note one accepted beat: update tables or queue the expected hit result
		function void note(bit f, bit [2:0] a, bit [7:0] bi, bit [13:0] wv, bit [8:0] win,
				bit [23:0] sb, bit [23:0] hw);
			hit_result_t r;
			longint s1, s2, t1, t2;
			if (f == FUNC_LOAD) begin
				if (bi < BINS) begin
					widths[a][bi] = wv;
					loaded[a] = 1;
				end
				return;
			end
			r = '{default: 0};
			if (!loaded[a]) begin
				r.status = 1;
			end else begin
				s1 = longint'(sb) + ((longint'(win[1:0]) * WINDOW_SAMPLES_D) << FRAC_BITS);
				s2 = s1 + hw;
				t1 = ring_time(a, s1);
				t2 = ring_time(a, s2);
				r.cstart = 27'(clip(t1, 0, 134217727));
				r.cwidth = 27'(clip(t2 - t1, -67108864, 67108863));
				r.dlt = 27'(clip(s1 - t1, -67108864, 67108863));
			end
			pending.insert(pending.size(), r);
		endfunction

		task report(string what, longint got, longint want);
			$display("mismatch on %s: got %0h, expected %0h", what, got, want);
			errors++;
		endtask

		task check(bit st, bit [26:0] cs, bit [26:0] cw, bit [26:0] dl);
			hit_result_t r;
			if (pending.size() == 0) begin
				report("unexpected result", st, 0);
				return;
			end
			r = pending.pop_front();
			if (st != r.status) report("status", st, r.status);
			if (cs != r.cstart) report("corrected_start", cs, r.cstart);
			if (cw != r.cwidth) report("corrected_width", cw, r.cwidth);
			if (dl != r.dlt) report("delta", dl, r.dlt);
		endtask
	endclass

	logic        clk, arst_n, start, busy, func;
	logic [2:0]  asic;
	logic [7:0]  bin_index;
	logic [13:0] width_value;
	logic [8:0]  window;
	logic [23:0] start_bin, hit_width;
	logic        strobe, status;
	logic [26:0] corrected_start;
	logic signed [26:0] corrected_width, delta;

	hit_scoreboard sb = new();
	int  cycles = 0;
	bit  calm;

	sample_time_correction dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Check each strobed result beat
	always @(posedge clk) begin
		if (arst_n && strobe) sb.check(status, corrected_start, corrected_width, delta);
	end

	// Abort on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("sample_time_correction_tb: done, errors");
			$finish;
		end
	end

	// Present one beat, hold until taken, then maybe idle for a burst
	task send(bit f, bit [2:0] a, bit [7:0] bi, bit [13:0] wv, bit [8:0] win,
			bit [23:0] sbn, bit [23:0] hw);
		start <= 1;
		func <= f;
		asic <= a;
		bin_index <= bi;
		width_value <= wv;
		window <= win;
		start_bin <= sbn;
		hit_width <= hw;
		do @(posedge clk); while (busy);
		sb.note(f, a, bi, wv, win, sbn, hw);
		if (!calm && $urandom_range(0, 7) == 0) begin
			start <= 0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task hit(bit [2:0] a, bit [8:0] win, bit [23:0] sbn, bit [23:0] hw);
		send(FUNC_HIT, a, 8'($urandom), 14'($urandom), win, sbn, hw);
	endtask

	// Fill a whole table: mode 0 fixed value, otherwise random widths
	task fill(bit [2:0] a, bit rnd, bit [13:0] wv);
		for (int i = 0; i < BINS; i++)
			send(FUNC_LOAD, a, 8'(i), rnd ? 14'($urandom) : wv, 9'd0, 24'd0, 24'd0);
	endtask

	initial begin
		bit [2:0] a;
		int n;
		sb.clear();
		calm = 0;
		arst_n = 0;
		start = 0;
		func = 0;
		asic = 0;
		bin_index = 0;
		width_value = 0;
		window = 0;
		start_bin = 0;
		hit_width = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Missing tables, and an out-of-range load that must not mark a table
		hit(3'd0, 9'd0, 24'd0, 24'd0);
		send(FUNC_LOAD, 3'd7, 8'hFF, 14'h3FFF, 9'd0, 24'd0, 24'd0);
		hit(3'd7, 9'h1FF, 24'hFFFFFF, 24'hFFFFFF);
		fill(3'd0, 1'b0, 14'd4096);
		fill(3'd1, 1'b0, 14'h3FFF);
		fill(3'd2, 1'b0, 14'd0);
		fill(3'd3, 1'b1, 14'd0);
		// Extremes, last bin of the ring and ring crossings
		hit(3'd0, 9'd0, 24'd0, 24'd0);
		hit(3'd0, 9'h1FF, 24'hFFFFFF, 24'hFFFFFF);
		hit(3'd1, 9'd3, 24'd1044480 + 24'd2048, 24'd4095);
		hit(3'd1, 9'd0, 24'hFFFFFF, 24'hFFFFFF);
		hit(3'd1, 9'd2, 24'd1040000, 24'd3000000);
		hit(3'd2, 9'd1, 24'd123456, 24'd777);
		hit(3'd2, 9'd3, 24'hFFFFFF, 24'd0);
		hit(3'd3, 9'd2, 24'h0FF800, 24'h000800);
		hit(3'd3, 9'h100, 24'h555555, 24'hAAAAAA);
		hit(3'd6, 9'd0, 24'h1000, 24'h1000);

		// Random hits, table rewrites and ignored loads
		for (int i = 0; i < 280; i++) begin
			if (i > 240) calm = 1;
			n = $urandom_range(0, 9);
			a = 3'($urandom);
			if (n < 2) begin
				a = 3'($urandom_range(0, 3));
				send(FUNC_LOAD, a, 8'($urandom_range(0, BINS - 1)), 14'($urandom),
					9'($urandom), 24'($urandom), 24'($urandom));
			end else if (n == 2) begin
				send(FUNC_LOAD, a, 8'hFF, 14'($urandom), 9'($urandom), 24'($urandom),
					24'($urandom));
			end else if (n < 6) begin
				hit(a, 9'($urandom), 24'($urandom), 24'($urandom_range(0, 1 << 16)));
			end else begin
				hit(a, 9'($urandom), 24'($urandom), 24'($urandom));
			end
		end
		start <= 0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("sample_time_correction_tb: done, clean");
		else
			$display("sample_time_correction_tb: done, errors");
		$finish;
	end
endmodule
